### src/lkvc_pkg.sv
package lkvc_pkg;

    // Cache geometry
    localparam int ENTRIES = 16;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int OCC_W   = $clog2(ENTRIES + 1);

    // Field widths
    localparam int KEY_W   = 32;
    localparam int VAL_W   = 32;
    localparam int CFG_W   = 5;

    // Stream widths: input tdata = {write_value, lookup_key}
    localparam int IN_TDATA_W   = KEY_W + VAL_W;
    localparam int OUT_FIELDS_W = 1 + VAL_W + 1 + KEY_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;

    // Capacity after reset
    localparam logic [CFG_W-1:0] CAP_RESET = CFG_W'(16);

    // Operation codes
    localparam logic OP_GET = 1'b0;
    localparam logic OP_SET = 1'b1;

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [OCC_W-1:0] occ_t;
    typedef logic [KEY_W-1:0] key_t;
    typedef logic [VAL_W-1:0] val_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_COMPARE,
        ST_UPDATE
    } lkvc_state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;
        logic compare;
        logic update;
    } lkvc_cmd_t;

endpackage

### src/lkvc_ctrl.sv
module lkvc_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    output lkvc_pkg::lkvc_cmd_t cmd
);

    lkvc_pkg::lkvc_state_t state_reg;
    lkvc_pkg::lkvc_state_t state_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic                  update_fire;

    // Update may proceed once the output register is free or being drained
    assign update_fire = (state_reg == lkvc_pkg::ST_UPDATE) && (!out_valid_reg || m_tready);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lkvc_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = lkvc_pkg::ST_COMPARE;
                end
            end
            lkvc_pkg::ST_COMPARE:
            begin
                state_next = lkvc_pkg::ST_UPDATE;
            end
            lkvc_pkg::ST_UPDATE:
            begin
                if (update_fire)
                begin
                    state_next = lkvc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lkvc_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs and commands
    always_comb
    begin
        s_tready    = 1'b0;
        cmd.load    = 1'b0;
        cmd.compare = 1'b0;
        cmd.update  = 1'b0;
        unique case (state_reg)
            lkvc_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            lkvc_pkg::ST_COMPARE:
            begin
                cmd.compare = 1'b1;
            end
            lkvc_pkg::ST_UPDATE:
            begin
                cmd.update = update_fire;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    // Hold the result until taken, refill on update
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (update_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lkvc_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### src/lkvc_datapath.sv
module lkvc_datapath (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  lkvc_pkg::lkvc_cmd_t                  cmd,
    input  logic [lkvc_pkg::IN_TDATA_W-1:0]      s_tdata,
    input  logic [0:0]                           s_tuser,
    output logic [lkvc_pkg::OUT_TDATA_W-1:0]     m_tdata,
    input  logic                                 cfg_wr_en,
    input  logic [lkvc_pkg::CFG_W-1:0]           cfg_wr_data
);

    // Accepted item
    logic              op_reg;
    lkvc_pkg::key_t    key_reg;
    lkvc_pkg::val_t    wval_reg;

    // Entry storage
    lkvc_pkg::key_t    keys_reg  [lkvc_pkg::ENTRIES];
    lkvc_pkg::val_t    vals_reg  [lkvc_pkg::ENTRIES];
    lkvc_pkg::idx_t    rank_reg  [lkvc_pkg::ENTRIES];
    logic [lkvc_pkg::ENTRIES-1:0] valid_reg;
    lkvc_pkg::occ_t    occ_reg;
    logic [lkvc_pkg::CFG_W-1:0]   cap_reg;

    // Compare results
    logic              hit_reg;
    logic              full_reg;
    lkvc_pkg::idx_t    hit_idx_reg;
    lkvc_pkg::idx_t    lru_idx_reg;
    lkvc_pkg::idx_t    free_idx_reg;
    lkvc_pkg::idx_t    hit_rank_reg;

    // Output register
    logic              found_reg;
    lkvc_pkg::val_t    rdval_reg;
    logic              ev_reg;
    lkvc_pkg::key_t    evkey_reg;

    // Combinational
    logic [lkvc_pkg::ENTRIES-1:0] match;
    logic              hit;
    lkvc_pkg::idx_t    hit_idx;
    lkvc_pkg::idx_t    lru_idx;
    lkvc_pkg::idx_t    free_idx;
    lkvc_pkg::idx_t    lru_rank;
    lkvc_pkg::occ_t    eff_cap;
    lkvc_pkg::idx_t    slot;
    logic              install;
    logic              promote;
    logic [lkvc_pkg::ENTRIES-1:0] age;

    // Effective capacity: zero acts as one, saturate at the entry count
    always_comb
    begin
        if (cap_reg == '0)
        begin
            eff_cap = lkvc_pkg::OCC_W'(1);
        end
        else if (int'(cap_reg) > lkvc_pkg::ENTRIES)
        begin
            eff_cap = lkvc_pkg::OCC_W'(lkvc_pkg::ENTRIES);
        end
        else
        begin
            eff_cap = lkvc_pkg::OCC_W'(cap_reg);
        end
    end

    // Least recent entry holds rank occupancy-1
    assign lru_rank = lkvc_pkg::IDX_W'(occ_reg - lkvc_pkg::OCC_W'(1));

    // Parallel key match and lowest-index selection
    always_comb
    begin
        hit      = 1'b0;
        hit_idx  = '0;
        lru_idx  = '0;
        free_idx = '0;
        for (int i = lkvc_pkg::ENTRIES - 1; i >= 0; i--)
        begin
            match[i] = valid_reg[i] && (keys_reg[i] == key_reg);
            if (match[i])
            begin
                hit     = 1'b1;
                hit_idx = lkvc_pkg::IDX_W'(i);
            end
            if (valid_reg[i] && (rank_reg[i] == lru_rank))
            begin
                lru_idx = lkvc_pkg::IDX_W'(i);
            end
            if (!valid_reg[i])
            begin
                free_idx = lkvc_pkg::IDX_W'(i);
            end
        end
    end

    // Pick the slot to touch and which entries age
    assign promote = hit_reg;
    assign install = (op_reg == lkvc_pkg::OP_SET) && !hit_reg;

    always_comb
    begin
        if (hit_reg)
        begin
            slot = hit_idx_reg;
        end
        else if (full_reg)
        begin
            slot = lru_idx_reg;
        end
        else
        begin
            slot = free_idx_reg;
        end
        for (int i = 0; i < lkvc_pkg::ENTRIES; i++)
        begin
            age[i] = valid_reg[i] && (lkvc_pkg::IDX_W'(i) != slot)
                     && (install || (promote && (rank_reg[i] < hit_rank_reg)));
        end
    end

    // Capture the item
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= s_tuser[0];
            key_reg  <= s_tdata[lkvc_pkg::KEY_W-1:0];
            wval_reg <= s_tdata[lkvc_pkg::IN_TDATA_W-1:lkvc_pkg::KEY_W];
        end
    end

    // Register the lookup
    always_ff @(posedge clk)
    begin
        if (cmd.compare)
        begin
            hit_reg      <= hit;
            full_reg     <= (occ_reg >= eff_cap);
            hit_idx_reg  <= hit_idx;
            lru_idx_reg  <= lru_idx;
            free_idx_reg <= free_idx;
            hit_rank_reg <= rank_reg[hit_idx];
        end
    end

    // Write keys and values, load the result
    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            if (op_reg == lkvc_pkg::OP_SET)
            begin
                vals_reg[slot] <= wval_reg;
            end
            if (install)
            begin
                keys_reg[slot] <= key_reg;
            end
            found_reg <= hit_reg;
            if (op_reg == lkvc_pkg::OP_SET)
            begin
                rdval_reg <= '0;
            end
            else if (hit_reg)
            begin
                rdval_reg <= vals_reg[hit_idx_reg];
            end
            else
            begin
                rdval_reg <= '1;
            end
            ev_reg    <= install && full_reg;
            evkey_reg <= (install && full_reg) ? keys_reg[lru_idx_reg] : '0;
        end
    end

    // Valid bits, ranks, occupancy and capacity
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            occ_reg   <= '0;
            cap_reg   <= lkvc_pkg::CAP_RESET;
            for (int i = 0; i < lkvc_pkg::ENTRIES; i++)
            begin
                rank_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_wr_en)
            begin
                cap_reg <= cfg_wr_data;
            end
            if (cmd.update)
            begin
                for (int i = 0; i < lkvc_pkg::ENTRIES; i++)
                begin
                    if (age[i])
                    begin
                        rank_reg[i] <= rank_reg[i] + lkvc_pkg::IDX_W'(1);
                    end
                end
                if (install || promote)
                begin
                    rank_reg[slot] <= '0;
                end
                if (install)
                begin
                    valid_reg[slot] <= 1'b1;
                    if (!full_reg)
                    begin
                        occ_reg <= occ_reg + lkvc_pkg::OCC_W'(1);
                    end
                end
            end
        end
    end

    // Result fields from bit 0 up: found, read_value, evicted, evicted_key
    assign m_tdata = {{lkvc_pkg::OUT_PAD_W{1'b0}}, evkey_reg, ev_reg, rdval_reg, found_reg};

`ifndef SYNTH
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(occ_reg) <= lkvc_pkg::ENTRIES)
        else $error("occupancy beyond entry count");

    a_occ_valid: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_reg) == int'(occ_reg))
        else $error("occupancy does not match valid entries");

    a_key_unique: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(match))
        else $error("key present in more than one entry");

    a_install_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.update && install && !full_reg) |=> (occ_reg == $past(occ_reg) + lkvc_pkg::OCC_W'(1)))
        else $error("fill of a free entry did not raise occupancy");
`endif

endmodule

### src/lru_key_value_cache_unit.sv
// Each accepted item runs compare, then update; the result is registered at the update, raising m_tvalid.
// One item at a time, set by the compare-then-update sequence on the entry registers; the next item
// is taken while the previous result waits, and an update stalls while an untaken result is held.
// Reset (rst_n, asynchronous, active low): all entries invalid, ranks and occupancy zero,
// capacity 16, no result pending.
module lru_key_value_cache_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [lkvc_pkg::IN_TDATA_W-1:0]  s_tdata,  // lookup_key, write_value
    input  logic [0:0]                       s_tuser,  // operation
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [lkvc_pkg::OUT_TDATA_W-1:0] m_tdata,  // found, read_value, evicted,
                                                       // evicted_key, zero padding
    input  logic                             cfg_wr_en,
    input  logic [lkvc_pkg::CFG_W-1:0]       cfg_wr_data
);

    lkvc_pkg::lkvc_cmd_t cmd;

    // Sequence each item
    lkvc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    // Entries, ranks and result register
    lkvc_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

endmodule

### sim/lru_key_value_cache_unit_test.sv
module lru_key_value_cache_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 3000;
    localparam int HOLD_CYCLES = 250;
    localparam int HOLD_AFTER  = 500;
    localparam int POOL_SIZE   = 32;

    typedef struct packed {
        logic             found;
        lkvc_pkg::val_t   read_value;
        logic             evicted;
        lkvc_pkg::key_t   evicted_key;
    } cache_reply_t;

    typedef enum logic {
        ROW_ITEM,
        ROW_CAP
    } row_kind_t;

    typedef struct {
        row_kind_t      kind;
        logic           op;
        lkvc_pkg::key_t key;
        lkvc_pkg::val_t wval;
        logic           typed;
        cache_reply_t   reply;
        int             cap;
    } script_row_t;

    localparam cache_reply_t GET_MISS = '{1'b0, '1, 1'b0, '0};
    localparam cache_reply_t SET_NEW  = '{1'b0, '0, 1'b0, '0};
    localparam cache_reply_t SET_HIT  = '{1'b1, '0, 1'b0, '0};

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    logic [lkvc_pkg::IN_TDATA_W-1:0]  s_tdata = '0;
    logic [0:0]                       s_tuser = '0;
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    logic [lkvc_pkg::OUT_TDATA_W-1:0] m_tdata;
    logic                             cfg_wr_en = 1'b0;
    logic [lkvc_pkg::CFG_W-1:0]       cfg_wr_data = '0;

    // Shadow copy of the cache contents
    lkvc_pkg::key_t             cached_key [lkvc_pkg::ENTRIES];
    lkvc_pkg::val_t             cached_val [lkvc_pkg::ENTRIES];
    logic                       cached_live[lkvc_pkg::ENTRIES];
    int                         age_rank   [lkvc_pkg::ENTRIES];
    int                         fill_count;
    logic [lkvc_pkg::CFG_W-1:0] cap_setting;

    cache_reply_t   replies_due[$];
    script_row_t    script[$];
    lkvc_pkg::key_t key_pool[POOL_SIZE];

    int   mismatch_count  = 0;
    int   replies_checked = 0;
    int   quiet_cycles    = 0;
    int   hold_left       = 0;
    logic held_off        = 1'b0;
    logic steady          = 1'b0;

    lru_key_value_cache_unit DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),     // lookup_key, write_value
        .s_tuser     (s_tuser),     // operation
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),     // found, read_value, evicted, evicted_key, padding
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Mostly short gaps, a few long ones, none in steady stretches
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(11, 40);
    endfunction

    // Make one entry the most recent; the more recent ones age by one
    function automatic void promote(int idx);
        int i;
        for (i = 0; i < lkvc_pkg::ENTRIES; i++)
            if (cached_live[i] && i != idx && age_rank[i] < age_rank[idx])
                age_rank[i]++;
        age_rank[idx] = 0;
    endfunction

    // Predict the reply to one item and advance the shadow cache
    function automatic cache_reply_t cache_access(logic op, lkvc_pkg::key_t key,
                                                  lkvc_pkg::val_t wval);
        cache_reply_t r;
        int           hit;
        int           slot;
        int           eff;
        int           best;
        int           i;
        r   = SET_NEW;
        hit = -1;
        for (i = 0; i < lkvc_pkg::ENTRIES; i++)
            if (hit < 0 && cached_live[i] && cached_key[i] == key)
                hit = i;
        if (op == lkvc_pkg::OP_GET)
        begin
            if (hit >= 0)
            begin
                r.found      = 1'b1;
                r.read_value = cached_val[hit];
                promote(hit);
            end
            else
                r.read_value = '1;
        end
        else if (hit >= 0)
        begin
            r.found         = 1'b1;
            cached_val[hit] = wval;
            promote(hit);
        end
        else
        begin
            eff  = (cap_setting == 0) ? 1 :
                   ((cap_setting > lkvc_pkg::ENTRIES) ? lkvc_pkg::ENTRIES : cap_setting);
            slot = -1;
            if (fill_count >= eff)
            begin
                // Evict the least recent live entry and reuse its slot
                best = -1;
                for (i = 0; i < lkvc_pkg::ENTRIES; i++)
                    if (cached_live[i] && age_rank[i] > best)
                    begin
                        best = age_rank[i];
                        slot = i;
                    end
                if (slot >= 0)
                begin
                    r.evicted         = 1'b1;
                    r.evicted_key     = cached_key[slot];
                    cached_live[slot] = 1'b0;
                    fill_count--;
                end
                else
                    slot = 0;
            end
            else
            begin
                for (i = 0; i < lkvc_pkg::ENTRIES; i++)
                    if (slot < 0 && !cached_live[i])
                        slot = i;
                if (slot < 0)
                    slot = 0;
            end
            for (i = 0; i < lkvc_pkg::ENTRIES; i++)
                if (cached_live[i] && i != slot)
                    age_rank[i]++;
            cached_key[slot]  = key;
            cached_val[slot]  = wval;
            cached_live[slot] = 1'b1;
            age_rank[slot]    = 0;
            fill_count++;
        end
        return r;
    endfunction

    function automatic void add_check(logic op, lkvc_pkg::key_t key, lkvc_pkg::val_t wval,
                                      cache_reply_t reply);
        script.push_back('{ROW_ITEM, op, key, wval, 1'b1, reply, 0});
    endfunction

    function automatic void add_pred(logic op, lkvc_pkg::key_t key, lkvc_pkg::val_t wval);
        script.push_back('{ROW_ITEM, op, key, wval, 1'b0, SET_NEW, 0});
    endfunction

    function automatic void add_cap(int cap);
        script.push_back('{ROW_CAP, lkvc_pkg::OP_GET, '0, '0, 1'b0, SET_NEW, cap});
    endfunction

    // Offer one item; entered and left at a falling edge
    task automatic offer_item(input logic op, input lkvc_pkg::key_t key,
                              input lkvc_pkg::val_t wval,
                              input logic typed, input cache_reply_t typed_reply);
        int           gap;
        cache_reply_t predicted;
        gap = pick_gap();
        repeat (gap)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = op;
        s_tdata  = {wval, key};
        do
            @(posedge clk);
        while (!s_tready);
        predicted = cache_access(op, key, wval);
        replies_due.push_back(typed ? typed_reply : predicted);
        @(negedge clk);
    endtask

    // Write the capacity once the block has gone quiet
    task automatic write_capacity(input int cap);
        s_tvalid = 1'b0;
        while (replies_due.size() != 0)
            @(negedge clk);
        repeat (6) @(negedge clk);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = lkvc_pkg::CFG_W'(cap);
        @(negedge clk);
        cfg_wr_en   = 1'b0;
        cap_setting = lkvc_pkg::CFG_W'(cap);
    endtask

    task automatic report(input string field, input logic [lkvc_pkg::KEY_W-1:0] want,
                          input logic [lkvc_pkg::KEY_W-1:0] got);
        $display("%0t ns: %s expected %h, got %h", $time, field, want, got);
        mismatch_count++;
    endtask

    // Toggle between steady stretches and stretches with gaps
    initial
    begin
        forever
        begin
            repeat ($urandom_range(40, 300)) @(posedge clk);
            steady = ($urandom_range(0, 2) == 0);
        end
    end

    // Result side: drive ready at the falling edge, check at the rising edge
    initial
    begin
        cache_reply_t want;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (!held_off && replies_checked >= HOLD_AFTER && s_tvalid)
            begin
                held_off  = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                m_tready = 1'b0;
                hold_left--;
            end
            else
            begin
                m_tready  = 1'b1;
                hold_left = pick_gap();
            end
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                if (replies_due.size() == 0)
                begin
                    $display("%0t ns: result with nothing expected, got %h", $time, m_tdata);
                    mismatch_count++;
                end
                else
                begin
                    want = replies_due.pop_front();
                    replies_checked++;
                    if (m_tdata[0] !== want.found)
                        report("found", want.found, m_tdata[0]);
                    if (m_tdata[lkvc_pkg::VAL_W:1] !== want.read_value)
                        report("read_value", want.read_value, m_tdata[lkvc_pkg::VAL_W:1]);
                    if (m_tdata[lkvc_pkg::VAL_W+1] !== want.evicted)
                        report("evicted", want.evicted, m_tdata[lkvc_pkg::VAL_W+1]);
                    if (m_tdata[lkvc_pkg::VAL_W+2 +: lkvc_pkg::KEY_W] !== want.evicted_key)
                        report("evicted_key", want.evicted_key,
                               m_tdata[lkvc_pkg::VAL_W+2 +: lkvc_pkg::KEY_W]);
                    if ((m_tdata >> lkvc_pkg::OUT_FIELDS_W) !== '0)
                        report("padding", '0,
                               lkvc_pkg::KEY_W'(m_tdata >> lkvc_pkg::OUT_FIELDS_W));
                end
            end
        end
    end

    // Watchdog on cycles with no handshake at all
    always @(posedge clk)
    begin
        if (!rst_n || cfg_wr_en || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("lru_key_value_cache_unit_test: errors");
            $finish;
        end
    end

    initial
    begin
        int             i;
        int             phase;
        int             n;
        int             cap;
        int             eff;
        int             span;
        logic           op;
        lkvc_pkg::key_t key;
        int             phase_caps[9];

        phase_caps = '{16, 1, 31, 0, 3, 8, 17, 15, -1};
        for (i = 0; i < lkvc_pkg::ENTRIES; i++)
        begin
            cached_key[i]  = '0;
            cached_val[i]  = '0;
            cached_live[i] = 1'b0;
            age_rank[i]    = 0;
        end
        fill_count  = 0;
        cap_setting = lkvc_pkg::CAP_RESET;

        key_pool[0] = 32'h0000_0000;
        key_pool[1] = 32'hFFFF_FFFF;
        key_pool[2] = 32'h8000_0000;
        key_pool[3] = 32'h7FFF_FFFF;
        for (i = 4; i < POOL_SIZE; i++)
            key_pool[i] = $urandom;

        // Hold reset low from time zero, then release it at a falling edge
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed part at reset capacity: misses, extremes, update in place
        add_check(lkvc_pkg::OP_GET, 32'h0000_0000, 32'h0000_0000, GET_MISS);
        add_check(lkvc_pkg::OP_GET, 32'h8000_0000, 32'hFFFF_FFFF, GET_MISS);
        add_check(lkvc_pkg::OP_SET, 32'h7FFF_FFFF, 32'h8000_0000, SET_NEW);
        add_check(lkvc_pkg::OP_SET, 32'h8000_0000, 32'h7FFF_FFFF, SET_NEW);
        add_check(lkvc_pkg::OP_GET, 32'h7FFF_FFFF, 32'h0000_0000,
                  '{1'b1, 32'h8000_0000, 1'b0, '0});
        add_check(lkvc_pkg::OP_SET, 32'h7FFF_FFFF, 32'hFFFF_FFFF, SET_HIT);
        add_check(lkvc_pkg::OP_GET, 32'h7FFF_FFFF, 32'h1234_5678,
                  '{1'b1, 32'hFFFF_FFFF, 1'b0, '0});
        // Keys compare on all 32 bits
        add_check(lkvc_pkg::OP_GET, 32'hFFFF_FFFF, 32'h0000_0000, GET_MISS);
        add_check(lkvc_pkg::OP_SET, 32'h0000_0000, 32'h0000_0000, SET_NEW);
        add_check(lkvc_pkg::OP_SET, 32'hFFFF_FFFF, 32'hAAAA_AAAA, SET_NEW);
        add_check(lkvc_pkg::OP_GET, 32'h8000_0000, 32'h5555_5555,
                  '{1'b1, 32'h7FFF_FFFF, 1'b0, '0});
        // Capacity lowered below occupancy: one eviction per new key
        add_cap(2);
        add_check(lkvc_pkg::OP_SET, 32'h1234_5678, 32'h5555_5555,
                  '{1'b0, '0, 1'b1, 32'h7FFF_FFFF});
        add_check(lkvc_pkg::OP_SET, 32'h0000_0001, 32'h0000_0001,
                  '{1'b0, '0, 1'b1, 32'h0000_0000});
        add_check(lkvc_pkg::OP_GET, 32'h7FFF_FFFF, 32'h0000_0000, GET_MISS);
        add_pred(lkvc_pkg::OP_GET, 32'hFFFF_FFFF, 32'h0000_0000);
        // Capacity zero behaves as one
        add_cap(0);
        add_pred(lkvc_pkg::OP_SET, 32'hDEAD_BEEF, 32'h0BAD_F00D);
        add_pred(lkvc_pkg::OP_SET, 32'h0000_0002, 32'hFFFF_FFFF);
        add_pred(lkvc_pkg::OP_GET, 32'hDEAD_BEEF, 32'h0000_0000);
        // Capacity above the entry count saturates
        add_cap(31);
        add_pred(lkvc_pkg::OP_SET, 32'hC0DE_0001, 32'h1111_1111);
        add_pred(lkvc_pkg::OP_SET, 32'hC0DE_0002, 32'h2222_2222);
        add_pred(lkvc_pkg::OP_SET, 32'h0000_0002, 32'h3333_3333);
        add_pred(lkvc_pkg::OP_GET, 32'h0000_0002, 32'h0000_0000);
        add_pred(lkvc_pkg::OP_GET, 32'hC0DE_0001, 32'h0000_0000);

        foreach (script[row])
        begin
            if (script[row].kind == ROW_CAP)
                write_capacity(script[row].cap);
            else
                offer_item(script[row].op, script[row].key, script[row].wval,
                           script[row].typed, script[row].reply);
        end

        // Random phases over a spread of capacities
        for (phase = 0; phase < 9; phase++)
        begin
            cap = (phase_caps[phase] < 0) ? $urandom_range(0, 31) : phase_caps[phase];
            write_capacity(cap);
            eff  = (cap == 0) ? 1 : ((cap > lkvc_pkg::ENTRIES) ? lkvc_pkg::ENTRIES : cap);
            span = eff + eff / 2 + 2;
            if (span > POOL_SIZE)
                span = POOL_SIZE;
            n = $urandom_range(120, 160);
            repeat (n)
            begin
                op = ($urandom_range(0, 99) < 45) ? lkvc_pkg::OP_GET : lkvc_pkg::OP_SET;
                if ($urandom_range(0, 99) < 85)
                    key = key_pool[$urandom_range(0, span - 1)];
                else
                    key = $urandom;
                offer_item(op, key, $urandom, 1'b0, SET_NEW);
            end
        end

        // Drain and let the pipeline settle
        s_tvalid = 1'b0;
        while (replies_due.size() != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);

        if (mismatch_count == 0)
            $display("lru_key_value_cache_unit_test: clean");
        else
            $display("lru_key_value_cache_unit_test: errors");
        $finish;
    end

endmodule

### lru_key_value_cache_unit.f
src/lkvc_pkg.sv
src/lkvc_ctrl.sv
src/lkvc_datapath.sv
src/lru_key_value_cache_unit.sv
sim/lru_key_value_cache_unit_test.sv
